[rtl/core/lrs_pkg.sv]
package lrs_pkg;

   localparam int MAX_COLS_DEF = 64;
   localparam int MAX_ROWS_DEF = 64;

   localparam int ACC_W   = 40;
   localparam int HIT_W   = 13;
   localparam int STEP_W  = 31;
   localparam int COORD_W = 32;
   localparam int CNT_W   = 7;
   localparam int DIV_W   = 62;   // magnitude bits of a dividend
   localparam int DIVQ_W  = 35;   // signed quotient bits kept

   localparam logic [1:0] CMD_SIEVE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [1:0] CSR_U_LOW   = 2'd0;
   localparam logic [1:0] CSR_V_LOW   = 2'd1;
   localparam logic [1:0] CSR_U_COUNT = 2'd2;
   localparam logic [1:0] CSR_V_COUNT = 2'd3;

   localparam logic [HIT_W-1:0] HIT_MAX = '1;

   typedef struct packed {
      logic [1:0]                command;
      logic signed [COORD_W-1:0] origin_u;
      logic signed [COORD_W-1:0] origin_v;
      logic [STEP_W-1:0]         step_u;
      logic [STEP_W-1:0]         step_v;
      logic signed [COORD_W-1:0] skew;
      logic signed [COORD_W-1:0] contribution;
      logic [5:0]                read_col;
      logic [5:0]                read_row;
   } req_type;

   typedef struct packed {
      logic [HIT_W-1:0]        hit_count;
      logic signed [ACC_W-1:0] cell_value;
   } rsp_type;

   typedef enum logic [2:0] {
      DSEL_DV, DSEL_A, DSEL_B, DSEL_SK, DSEL_C
   } div_sel_type;

   typedef enum logic [1:0] {
      RES_ZERO, RES_SIEVE, RES_READ
   } res_kind_type;

   typedef enum logic [3:0] {
      ST_INIT_CLR, ST_IDLE, ST_DECODE, ST_RD, ST_CLR, ST_DIV_GO, ST_DIV_WAIT,
      ST_MUL, ST_COL, ST_ROW, ST_CHK, ST_RMW, ST_DONE
   } state_type;

   typedef struct packed {
      logic         load_req;
      logic         clr_init;
      logic         clr_step;
      logic         div_start;
      logic         div_take;
      div_sel_type  div_sel;
      logic         mul_en;
      logic         col_en;
      logic         walk_init;
      logic         rd_walk;
      logic         rd_read;
      logic         rmw_wr;
      logic         row_next;
      logic         res_load;
      res_kind_type res_kind;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic       step_zero;
      logic       div_done;
      logic       row_in;
      logic       k_in;
      logic       clr_last;
   } dp_stat_type;

endpackage

[rtl/core/lattice_rectangle_sieve.sv]
// Lattice sieve over a MAX_COLS x MAX_ROWS rectangle of 40-bit Q24.16
// accumulators, one word at a time. After reset the block zeroes the
// accumulator memory, one cell a cycle, before taking the first word; a
// clear command zeroes it the same way. A sieve runs five floor divisions
// through one radix-2 divider plus a multiply, then, for each hit cell, a
// read and a write back (read-modify-write on the accumulator memory), and
// a row step for each lattice row visited; the walk length depends on the
// data. The result register lets the next word in while a result waits.
module lattice_rectangle_sieve #(
   parameter int MAX_COLS = lrs_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = lrs_pkg::MAX_ROWS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lrs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lrs_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata
);
   lrs_pkg::ctl_cmd_type cmd;
   lrs_pkg::dp_stat_type stat;

   lrs_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lrs_datapath #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/core/lrs_divider.sv]
// Restoring divider, one quotient bit per cycle; floor semantics on a signed
// dividend given as sign and magnitude, remainder always non-negative.
module lrs_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                neg,
   input  logic [lrs_pkg::DIV_W-1:0]           mag,
   input  logic [lrs_pkg::STEP_W-1:0]          divisor,
   output logic                                done,
   output logic signed [lrs_pkg::DIVQ_W-1:0]   quot,
   output logic [lrs_pkg::STEP_W-1:0]          rem
);
   localparam int CW = $clog2(lrs_pkg::DIV_W);
   localparam int SW = lrs_pkg::STEP_W;
   localparam int QW = lrs_pkg::DIVQ_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [lrs_pkg::DIV_W-1:0] dvd_ff, dvd_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic          neg_ff, neg_in;
   logic [SW:0]   rem_sh;
   logic [SW:0]   rem_sub;
   logic          rem_nz;
   logic [QW-1:0] qm;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      rem_sh  = {rem_ff, dvd_ff[lrs_pkg::DIV_W-1]};
      rem_sub = rem_sh - {1'b0, divisor};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = mag;
         rem_in  = '0;
         neg_in  = neg;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, divisor}) begin
            rem_in = rem_sub[SW-1:0];
            dvd_in = {dvd_ff[lrs_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[SW-1:0];
            dvd_in = {dvd_ff[lrs_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(lrs_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   // negative dividend with a remainder: quotient one lower, remainder d - r
   always_comb begin
      rem_nz = (rem_ff != '0);
      qm     = dvd_ff[QW-1:0];
      if (neg_ff && rem_nz) begin
         quot = -(qm + QW'(1));
         rem  = divisor - rem_ff;
      end else if (neg_ff) begin
         quot = -qm;
         rem  = rem_ff;
      end else begin
         quot = qm;
         rem  = rem_ff;
      end
   end

   assign done = done_ff;

endmodule

[rtl/core/lrs_datapath.sv]
module lrs_datapath #(
   parameter int MAX_COLS = lrs_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = lrs_pkg::MAX_ROWS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lrs_pkg::req_type     req_data,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_wdata,
   input  lrs_pkg::ctl_cmd_type cmd,
   output lrs_pkg::dp_stat_type stat,
   output lrs_pkg::rsp_type     rsp_data
);
   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW    = lrs_pkg::STEP_W;
   localparam int ACCW  = lrs_pkg::ACC_W;
   localparam int HW    = lrs_pkg::HIT_W;

   lrs_pkg::req_type req_ff, req_in;
   logic signed [31:0] u_low_ff, u_low_in, v_low_ff, v_low_in;
   logic [lrs_pkg::CNT_W-1:0] u_count_ff, u_count_in, v_count_ff, v_count_in;
   logic [31:0] row_ff, row_in;
   logic signed [lrs_pkg::DIVQ_W-1:0] q_ff, q_in;
   logic [SW-1:0] a_ff, a_in, b_ff, b_in, skm_ff, skm_in, c_ff, c_in, col_ff, col_in;
   logic [2*SW-1:0] prod_ff, prod_in;
   logic [31:0] k_ff, k_in;
   logic [HW-1:0] hits_ff, hits_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   lrs_pkg::rsp_type rsp_ff, rsp_in;

   logic [ACCW-1:0] acc_mem [DEPTH];
   logic [ACCW-1:0] mem_rd_ff;

   logic [31:0] cols_eff, rows_eff;
   logic [AW-1:0] walk_addr, read_addr, rd_addr, wr_addr;
   logic [ACCW-1:0] wr_data;
   logic mem_we, mem_re, read_ok;
   logic signed [ACCW:0] sum;
   logic [ACCW-1:0] sat;
   logic signed [63:0] dvd_x, dvd_abs;
   logic [SW-1:0] divisor;
   logic div_done;
   logic signed [lrs_pkg::DIVQ_W-1:0] div_q;
   logic [SW-1:0] div_r;
   logic [SW:0] col_sum, col_dif;

   assign cols_eff = (32'(u_count_ff) > 32'(MAX_COLS)) ? 32'(MAX_COLS) : 32'(u_count_ff);
   assign rows_eff = (32'(v_count_ff) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : 32'(v_count_ff);

   assign walk_addr = AW'(row_ff * 32'(MAX_COLS) + k_ff);
   assign read_addr = AW'(32'(req_ff.read_row) * 32'(MAX_COLS) + 32'(req_ff.read_col));
   assign read_ok   = (32'(req_ff.read_col) < cols_eff) && (32'(req_ff.read_row) < rows_eff);

   // dividend select, sign and magnitude for the shared divider
   always_comb begin
      case (cmd.div_sel)
         lrs_pkg::DSEL_DV: dvd_x = 64'(req_ff.origin_v) - 64'(v_low_ff);
         lrs_pkg::DSEL_A:  dvd_x = 64'(req_ff.origin_u) - 64'(u_low_ff);
         lrs_pkg::DSEL_B:  dvd_x = 64'(q_ff);
         lrs_pkg::DSEL_SK: dvd_x = 64'(req_ff.skew);
         lrs_pkg::DSEL_C:  dvd_x = $signed({2'b00, prod_ff});
         default:          dvd_x = '0;
      endcase
      dvd_abs = dvd_x[63] ? -dvd_x : dvd_x;
      divisor = (cmd.div_sel == lrs_pkg::DSEL_DV) ? req_ff.step_v : req_ff.step_u;
   end

   lrs_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .neg     (dvd_x[63]),
      .mag     (dvd_abs[lrs_pkg::DIV_W-1:0]),
      .divisor (divisor),
      .done    (div_done),
      .quot    (div_q),
      .rem     (div_r)
   );

   // saturating accumulate into Q24.16
   always_comb begin
      sum = $signed({mem_rd_ff[ACCW-1], mem_rd_ff}) + (ACCW+1)'(req_ff.contribution);
      if (sum[ACCW] != sum[ACCW-1])
         sat = sum[ACCW] ? {1'b1, {(ACCW-1){1'b0}}} : {1'b0, {(ACCW-1){1'b1}}};
      else
         sat = sum[ACCW-1:0];
   end

   assign col_dif = {1'b0, a_ff} + {1'b0, req_ff.step_u} - {1'b0, c_ff};
   assign col_sum = {1'b0, col_ff} + {1'b0, skm_ff};

   always_comb begin
      req_in      = req_ff;
      u_low_in    = u_low_ff;
      v_low_in    = v_low_ff;
      u_count_in  = u_count_ff;
      v_count_in  = v_count_ff;
      row_in      = row_ff;
      q_in        = q_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      skm_in      = skm_ff;
      c_in        = c_ff;
      col_in      = col_ff;
      prod_in     = prod_ff;
      k_in        = k_ff;
      hits_in     = hits_ff;
      clr_addr_in = clr_addr_ff;
      rsp_in      = rsp_ff;

      if (csr_we) begin
         case (csr_index)
            lrs_pkg::CSR_U_LOW:   u_low_in   = csr_wdata;
            lrs_pkg::CSR_V_LOW:   v_low_in   = csr_wdata;
            lrs_pkg::CSR_U_COUNT: u_count_in = csr_wdata[lrs_pkg::CNT_W-1:0];
            lrs_pkg::CSR_V_COUNT: v_count_in = csr_wdata[lrs_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
      if (cmd.load_req) begin
         req_in  = req_data;
         hits_in = '0;
      end
      if (cmd.clr_init) clr_addr_in = '0;
      if (cmd.clr_step) clr_addr_in = clr_addr_ff + 1'b1;
      if (cmd.div_take && div_done) begin
         case (cmd.div_sel)
            lrs_pkg::DSEL_DV: begin
               row_in = 32'(div_r);
               q_in   = div_q;
            end
            lrs_pkg::DSEL_A:  a_in   = div_r;
            lrs_pkg::DSEL_B:  b_in   = div_r;
            lrs_pkg::DSEL_SK: skm_in = div_r;
            lrs_pkg::DSEL_C:  c_in   = div_r;
            default: ;
         endcase
      end
      if (cmd.mul_en) prod_in = b_ff * skm_ff;
      if (cmd.col_en)
         col_in = (a_ff >= c_ff) ? (a_ff - c_ff) : col_dif[SW-1:0];
      if (cmd.walk_init) k_in = {1'b0, col_ff};
      if (cmd.rmw_wr) begin
         k_in = k_ff + {1'b0, req_ff.step_u};
         if (hits_ff != lrs_pkg::HIT_MAX) hits_in = hits_ff + 1'b1;
      end
      if (cmd.row_next) begin
         col_in = (col_sum >= {1'b0, req_ff.step_u}) ?
                  SW'(col_sum - {1'b0, req_ff.step_u}) : col_sum[SW-1:0];
         row_in = row_ff + {1'b0, req_ff.step_v};
      end
      if (cmd.res_load) begin
         rsp_in.hit_count  = (cmd.res_kind == lrs_pkg::RES_SIEVE) ? hits_ff : '0;
         rsp_in.cell_value = (cmd.res_kind == lrs_pkg::RES_READ && read_ok) ?
                             mem_rd_ff : '0;
      end
   end

   assign mem_we  = cmd.clr_step || cmd.rmw_wr;
   assign wr_addr = cmd.clr_step ? clr_addr_ff : walk_addr;
   assign wr_data = cmd.clr_step ? '0 : sat;
   assign mem_re  = cmd.rd_walk || cmd.rd_read;
   assign rd_addr = cmd.rd_read ? read_addr : walk_addr;

   always_ff @(posedge clock) begin
      if (mem_we) acc_mem[wr_addr] <= wr_data;
      if (mem_re) mem_rd_ff <= acc_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         u_low_ff    <= '0;
         v_low_ff    <= '0;
         u_count_ff  <= lrs_pkg::CNT_W'(64);
         v_count_ff  <= lrs_pkg::CNT_W'(64);
         clr_addr_ff <= '0;
      end else begin
         u_low_ff    <= u_low_in;
         v_low_ff    <= v_low_in;
         u_count_ff  <= u_count_in;
         v_count_ff  <= v_count_in;
         clr_addr_ff <= clr_addr_in;
      end
      req_ff  <= req_in;
      row_ff  <= row_in;
      q_ff    <= q_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      skm_ff  <= skm_in;
      c_ff    <= c_in;
      col_ff  <= col_in;
      prod_ff <= prod_in;
      k_ff    <= k_in;
      hits_ff <= hits_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      stat.command   = req_ff.command;
      stat.step_zero = (req_ff.step_u == '0) || (req_ff.step_v == '0);
      stat.div_done  = div_done;
      stat.row_in    = row_ff < rows_eff;
      stat.k_in      = k_ff < cols_eff;
      stat.clr_last  = (clr_addr_ff == AW'(DEPTH - 1));
   end

   assign rsp_data = rsp_ff;

endmodule

[rtl/core/lrs_controller.sv]
module lrs_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  lrs_pkg::dp_stat_type stat,
   output lrs_pkg::ctl_cmd_type cmd
);
   lrs_pkg::state_type    state_ff, state_in;
   lrs_pkg::div_sel_type  dsel_ff, dsel_in;
   lrs_pkg::res_kind_type kind_ff, kind_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      dsel_in      = dsel_ff;
      kind_in      = kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.div_sel  = dsel_ff;
      cmd.res_kind = kind_ff;

      case (state_ff)
         lrs_pkg::ST_INIT_CLR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) state_in = lrs_pkg::ST_IDLE;
         end
         lrs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = lrs_pkg::ST_DECODE;
            end
         end
         lrs_pkg::ST_DECODE: begin
            kind_in  = lrs_pkg::RES_ZERO;
            state_in = lrs_pkg::ST_DONE;
            case (stat.command)
               lrs_pkg::CMD_SIEVE: begin
                  if (!stat.step_zero) begin
                     dsel_in  = lrs_pkg::DSEL_DV;
                     state_in = lrs_pkg::ST_DIV_GO;
                  end
               end
               lrs_pkg::CMD_READ: state_in = lrs_pkg::ST_RD;
               lrs_pkg::CMD_CLEAR: begin
                  cmd.clr_init = 1'b1;
                  state_in     = lrs_pkg::ST_CLR;
               end
               default: ;
            endcase
         end
         lrs_pkg::ST_RD: begin
            cmd.rd_read = 1'b1;
            kind_in     = lrs_pkg::RES_READ;
            state_in    = lrs_pkg::ST_DONE;
         end
         lrs_pkg::ST_CLR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) state_in = lrs_pkg::ST_DONE;
         end
         lrs_pkg::ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = lrs_pkg::ST_DIV_WAIT;
         end
         lrs_pkg::ST_DIV_WAIT: begin
            cmd.div_take = 1'b1;
            if (stat.div_done) begin
               state_in = lrs_pkg::ST_DIV_GO;
               case (dsel_ff)
                  lrs_pkg::DSEL_DV: dsel_in  = lrs_pkg::DSEL_A;
                  lrs_pkg::DSEL_A:  dsel_in  = lrs_pkg::DSEL_B;
                  lrs_pkg::DSEL_B:  dsel_in  = lrs_pkg::DSEL_SK;
                  lrs_pkg::DSEL_SK: state_in = lrs_pkg::ST_MUL;
                  default:          state_in = lrs_pkg::ST_COL;
               endcase
            end
         end
         lrs_pkg::ST_MUL: begin
            cmd.mul_en = 1'b1;
            dsel_in    = lrs_pkg::DSEL_C;
            state_in   = lrs_pkg::ST_DIV_GO;
         end
         lrs_pkg::ST_COL: begin
            cmd.col_en = 1'b1;
            state_in   = lrs_pkg::ST_ROW;
         end
         lrs_pkg::ST_ROW: begin
            if (stat.row_in) begin
               cmd.walk_init = 1'b1;
               state_in      = lrs_pkg::ST_CHK;
            end else begin
               kind_in  = lrs_pkg::RES_SIEVE;
               state_in = lrs_pkg::ST_DONE;
            end
         end
         lrs_pkg::ST_CHK: begin
            if (stat.k_in) begin
               cmd.rd_walk = 1'b1;
               state_in    = lrs_pkg::ST_RMW;
            end else begin
               cmd.row_next = 1'b1;
               state_in     = lrs_pkg::ST_ROW;
            end
         end
         lrs_pkg::ST_RMW: begin
            cmd.rmw_wr = 1'b1;
            state_in   = lrs_pkg::ST_CHK;
         end
         lrs_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.res_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = lrs_pkg::ST_IDLE;
            end
         end
         default: state_in = lrs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lrs_pkg::ST_INIT_CLR;
         rsp_valid_ff <= 1'b0;
         dsel_ff      <= lrs_pkg::DSEL_DV;
         kind_ff      <= lrs_pkg::RES_ZERO;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dsel_ff      <= dsel_in;
         kind_ff      <= kind_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/core/lrs_checker.sv]
module lrs_port_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input lrs_pkg::rsp_type rsp_data
);
   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // one word at a time: busy right after taking one
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accept");

   // memory sweep after reset: not ready and no result as it starts
   a_reset_sweep: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("activity during reset sweep");

   // a result carries a hit count or a cell, never both
   a_one_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit_count != '0 |-> rsp_data.cell_value == '0)
      else $error("hit count and cell value both set");

endmodule

bind lattice_rectangle_sieve lrs_port_checker u_lrs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[test/lrs_checker.sv]
module lrs_checker
   import lrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NCOLS = MAX_COLS_DEF;
   localparam int NROWS = MAX_ROWS_DEF;
   localparam longint SUM_MAX = 64'sd549755813887;
   localparam longint SUM_MIN = -64'sd549755813888;

   logic signed [ACC_W-1:0] cells [NCOLS*NROWS];
   longint  u_base, v_base;
   int      u_span, v_span;
   rsp_type expected_q [$];

   function automatic longint pos_mod(longint x, longint m);
      longint r;
      r = x % m;
      if (r < 0) r += m;
      return r;
   endfunction

   function automatic int clip(int c, int lim);
      return (c > lim) ? lim : c;
   endfunction

   // floor-based start point, then walk rows upward
   function automatic int unsigned sieve_cells(req_type w);
      longint su, sv, dv, q, row, col, a, b, skm, c, k, s, add;
      int unsigned hits;
      int cols, rows;
      su = longint'(w.step_u);
      sv = longint'(w.step_v);
      add = longint'($signed(w.contribution));
      cols = clip(u_span, NCOLS);
      rows = clip(v_span, NROWS);
      hits = 0;
      if (su == 0 || sv == 0) return 0;
      dv = longint'($signed(w.origin_v)) - v_base;
      row = pos_mod(dv, sv);
      q = (dv - row) / sv;
      a = pos_mod(longint'($signed(w.origin_u)) - u_base, su);
      b = pos_mod(q, su);
      skm = pos_mod(longint'($signed(w.skew)), su);
      c = (b * skm) % su;
      col = (a + su - c) % su;
      while (row < rows) begin
         for (k = col; k < cols; k += su) begin
            s = longint'(cells[row*NCOLS + k]) + add;
            if (s > SUM_MAX) s = SUM_MAX;
            if (s < SUM_MIN) s = SUM_MIN;
            cells[row*NCOLS + k] = s[ACC_W-1:0];
            if (hits < 8191) hits++;
         end
         col = (col + skm) % su;
         row += sv;
      end
      return hits;
   endfunction

   function automatic rsp_type predict_word(req_type w);
      rsp_type r;
      int unsigned hits;
      r = '0;
      case (w.command)
         CMD_SIEVE: begin
            hits = sieve_cells(w);
            r.hit_count = hits[HIT_W-1:0];
         end
         CMD_READ: begin
            if (w.read_col < clip(u_span, NCOLS) && w.read_row < clip(v_span, NROWS))
               r.cell_value = cells[w.read_row*NCOLS + w.read_col];
         end
         CMD_CLEAR: begin
            foreach (cells[i]) cells[i] = '0;
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (cells[i]) cells[i] = '0;
         u_base = 0;
         v_base = 0;
         u_span = 64;
         v_span = 64;
         expected_q.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_U_LOW:   u_base = longint'($signed(csr_wdata));
               CSR_V_LOW:   v_base = longint'($signed(csr_wdata));
               CSR_U_COUNT: u_span = int'(csr_wdata[CNT_W-1:0]);
               CSR_V_COUNT: v_span = int'(csr_wdata[CNT_W-1:0]);
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               if (fail_count < 10)
                  $display("%t: unexpected result word hit=%0d cell=%0d", $realtime,
                           rsp_data.hit_count, rsp_data.cell_value);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (want.hit_count !== rsp_data.hit_count ||
                   want.cell_value !== rsp_data.cell_value) begin
                  if (fail_count < 10)
                     $display("%t: hit exp %0d got %0d, cell exp %0d got %0d", $realtime,
                              want.hit_count, rsp_data.hit_count,
                              want.cell_value, rsp_data.cell_value);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready)
            expected_q.push_back(predict_word(req_data));
         pending <= expected_q.size();
      end
   end
endmodule

[test/tb.sv]
module tb;
   import lrs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;
   int          fail_count;
   int          pending;

   bit          calm;
   bit          saturate_mode;
   bit          saturate_neg;
   logic [31:0] cur_ulow, cur_vlow;
   int          cmd_tally [4];

   lattice_rectangle_sieve DUT (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_we, .csr_index, .csr_wdata
   );

   lrs_checker checker_i (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_we, .csr_index, .csr_wdata,
      .fail_count, .pending
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #500ms;
      $display("lattice_rectangle_sieve: mismatch");
      $finish;
   end

   // receiver stalls in bursts, with quiet stretches between
   always @(posedge clock) begin
      int stall_left, quiet_left;
      if (reset || calm) begin
         rsp_ready <= 1'b1;
         stall_left = 0;
         quiet_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= (stall_left == 0);
      end else if (quiet_left > 0) begin
         quiet_left--;
         rsp_ready <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
         quiet_left = $urandom_range(20, 200);
         rsp_ready <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 12);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_word(req_type w);
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      cmd_tally[w.command]++;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // leaves csr_we high; the caller drops it after the last write
   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_U_LOW) cur_ulow = value;
      if (idx == CSR_V_LOW) cur_vlow = value;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_rect(logic [31:0] ul, logic [31:0] vl, logic [31:0] uc,
                           logic [31:0] vc);
      write_reg(CSR_U_LOW, ul);
      write_reg(CSR_V_LOW, vl);
      write_reg(CSR_U_COUNT, uc);
      write_reg(CSR_V_COUNT, vc);
      csr_we <= 1'b0;
   endtask

   function automatic req_type make_word(logic [1:0] cmd, logic [31:0] ou, logic [31:0] ov,
                                         logic [30:0] su, logic [30:0] sv, logic [31:0] sk,
                                         logic [31:0] add, logic [5:0] rc, logic [5:0] rr);
      req_type w;
      w.command = cmd;
      w.origin_u = ou;
      w.origin_v = ov;
      w.step_u = su;
      w.step_v = sv;
      w.skew = sk;
      w.contribution = add;
      w.read_col = rc;
      w.read_row = rr;
      return w;
   endfunction

   function automatic req_type random_word();
      req_type w;
      int pick;
      w = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      pick = $urandom_range(0, 99);
      w.command = (pick < 60) ? CMD_SIEVE : (pick < 90) ? CMD_READ :
                  (pick < 97) ? CMD_CLEAR : CMD_UNUSED;
      if (saturate_mode) begin
         if (pick < 90) w.command = (pick < 70) ? CMD_SIEVE : CMD_READ;
         w.step_u = 1;
         w.step_v = 1;
         w.contribution = saturate_neg ? 32'h8000_0000 : 32'h7fff_ffff;
         return w;
      end
      if ($urandom_range(0, 1)) begin
         w.origin_u = cur_ulow + $urandom_range(0, 200) - 100;
         w.origin_v = cur_vlow + $urandom_range(0, 200) - 100;
      end
      pick = $urandom_range(0, 99);
      w.step_u = (pick < 5) ? 31'd0 : (pick < 15) ? 31'($urandom) : 31'($urandom_range(1, 40));
      pick = $urandom_range(0, 99);
      w.step_v = (pick < 5) ? 31'd0 : (pick < 15) ? 31'($urandom) : 31'($urandom_range(1, 20));
      pick = $urandom_range(0, 9);
      if (pick == 0) w.contribution = 32'h7fff_ffff;
      else if (pick == 1) w.contribution = 32'h8000_0000;
      else if (pick == 2) w.contribution = $urandom_range(0, 255) << 16;
      return w;
   endfunction

   task automatic random_phase(int n);
      repeat (n) send_word(random_word());
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_U_LOW;
      csr_wdata = '0;
      calm = 1'b0;
      saturate_mode = 1'b0;
      saturate_neg = 1'b0;
      cur_ulow = '0;
      cur_vlow = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default rectangle
      send_word(make_word(CMD_READ, 0, 0, 1, 1, 0, 0, 0, 0));
      send_word(make_word(CMD_SIEVE, 0, 0, 1, 1, 0, 32'h7fff_ffff, 0, 0));
      send_word(make_word(CMD_SIEVE, -7, -11, 3, 5, -4, 32'h8000_0000, 0, 0));
      send_word(make_word(CMD_SIEVE, 5, 5, 0, 3, 1, 32'h0001_0000, 0, 0));
      send_word(make_word(CMD_SIEVE, 5, 5, 3, 0, 1, 32'h0001_0000, 0, 0));
      send_word(make_word(CMD_SIEVE, 32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff,
                          31'h7fff_ffff, 32'h8000_0000, 32'h0002_0000, 0, 0));
      send_word(make_word(CMD_SIEVE, 32'h7fff_ffff, 32'h8000_0000, 7, 9,
                          32'h7fff_ffff, 32'hffff_0000, 0, 0));
      send_word(make_word(CMD_READ, 0, 0, 1, 1, 0, 0, 63, 63));
      send_word(make_word(CMD_READ, 0, 0, 1, 1, 0, 0, 0, 0));
      send_word(make_word(CMD_READ, 0, 0, 1, 1, 0, 0, 6, 10));
      send_word(make_word(CMD_UNUSED, 1, 1, 1, 1, 1, 1, 1, 1));
      send_word(make_word(CMD_CLEAR, 0, 0, 1, 1, 0, 0, 0, 0));
      send_word(make_word(CMD_READ, 0, 0, 1, 1, 0, 0, 0, 0));
      drain();

      // empty rectangle, then counts above the maximum
      set_rect(0, 0, 0, 64);
      send_word(make_word(CMD_SIEVE, 0, 0, 1, 1, 0, 32'h0001_0000, 0, 0));
      send_word(make_word(CMD_READ, 0, 0, 1, 1, 0, 0, 0, 0));
      drain();
      set_rect(32'hffff_fff0, 32'h10, 127, 127);
      send_word(make_word(CMD_SIEVE, 3, 20, 5, 3, -2, 32'h0003_8000, 0, 0));
      send_word(make_word(CMD_READ, 0, 0, 1, 1, 0, 0, 63, 63));
      send_word(make_word(CMD_READ, 0, 0, 1, 1, 0, 0, 3, 1));
      drain();

      // random phases across register settings
      set_rect(0, 0, 64, 64);
      random_phase(250);
      set_rect(32'h8000_0000, 32'h7fff_ffff, 127, 0);
      random_phase(100);
      set_rect($urandom, $urandom, $urandom_range(1, 64), $urandom_range(1, 64));
      random_phase(250);
      set_rect($urandom, $urandom, 2, 2);
      saturate_mode = 1'b1;
      random_phase(150);
      saturate_neg = 1'b1;
      random_phase(150);
      saturate_mode = 1'b0;
      set_rect(32'h7fff_ffff, 32'h8000_0000, 1, 127);
      random_phase(150);
      set_rect($urandom, $urandom, $urandom, $urandom);
      random_phase(100);
      calm = 1'b1;
      random_phase(100);

      $display("%0d words: %0d sieve, %0d read, %0d clear, %0d unused command",
               cmd_tally[0] + cmd_tally[1] + cmd_tally[2] + cmd_tally[3],
               cmd_tally[0], cmd_tally[1], cmd_tally[2], cmd_tally[3]);
      $display("rectangles: default, empty, oversized, random, 2x2 saturating, edge origins");
      if (fail_count == 0)
         $display("lattice_rectangle_sieve: match");
      else
         $display("lattice_rectangle_sieve: mismatch");
      $finish;
   end
endmodule
